/* hw/rtl/slfb_pkg.sv */
package slfb_pkg;

    localparam int unsigned COL_W      = 12;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned NCH        = 3;
    localparam int unsigned START_W    = 12;
    localparam int unsigned WIDTH_W    = 13;
    // p*(W-k) + t*k stays below 255 * 8191
    localparam int unsigned SUM_W      = PIX_W + WIDTH_W;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = WIDTH_W;

    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned WIDTH_LIM  = (1 << WIDTH_W) - 1;
    localparam logic [WIDTH_W-1:0] END_CAP =
        WIDTH_W'((MAX_WIDTH > WIDTH_LIM) ? WIDTH_LIM : MAX_WIDTH);

    localparam logic [START_W-1:0] START_RESET = '0;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(4096);

    localparam logic [CFG_IDX_W-1:0] REG_START_COLUMN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(1);

    typedef struct packed {
        logic [COL_W-1:0]            column;
        logic [NCH-1:0][PIX_W-1:0]   first;
        logic [NCH-1:0][PIX_W-1:0]   second;
    } slfb_pair_t;

    typedef struct packed {
        logic                        valid;
        logic [COL_W-1:0]            column;
        logic [WIDTH_W-1:0]          w;
        logic [NCH-1:0][SUM_W-1:0]   rem;
        logic [NCH-1:0][PIX_W-1:0]   quo;
    } slfb_div_t;

endpackage

/* hw/rtl/slfb_in_if.sv */
interface slfb_in_if;
    logic                          valid;
    logic                          ready;
    logic [slfb_pkg::COL_W-1:0]    column;
    logic [slfb_pkg::PIX_W-1:0]    first_c0;
    logic [slfb_pkg::PIX_W-1:0]    first_c1;
    logic [slfb_pkg::PIX_W-1:0]    first_c2;
    logic [slfb_pkg::PIX_W-1:0]    second_c0;
    logic [slfb_pkg::PIX_W-1:0]    second_c1;
    logic [slfb_pkg::PIX_W-1:0]    second_c2;

    modport source (
        output valid, column, first_c0, first_c1, first_c2,
               second_c0, second_c1, second_c2,
        input  ready
    );

    modport sink (
        input  valid, column, first_c0, first_c1, first_c2,
               second_c0, second_c1, second_c2,
        output ready
    );
endinterface

/* hw/rtl/slfb_out_if.sv */
interface slfb_out_if;
    logic                          valid;
    logic                          ready;
    logic [slfb_pkg::COL_W-1:0]    out_column;
    logic [slfb_pkg::PIX_W-1:0]    out_c0;
    logic [slfb_pkg::PIX_W-1:0]    out_c1;
    logic [slfb_pkg::PIX_W-1:0]    out_c2;

    modport source (
        output valid, out_column, out_c0, out_c1, out_c2,
        input  ready
    );

    modport sink (
        input  valid, out_column, out_c0, out_c1, out_c2,
        output ready
    );
endinterface

/* hw/rtl/slfb_front.sv */
module slfb_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [slfb_pkg::START_W-1:0]    start_col,
    input  logic [slfb_pkg::WIDTH_W-1:0]    end_col,
    input  logic                            in_valid,
    input  slfb_pkg::slfb_pair_t            in_data,
    output logic                            in_take,
    input  logic                            dn_take,
    output slfb_pkg::slfb_div_t             dn
);
    import slfb_pkg::*;

    logic                        s1_valid_reg;
    logic [COL_W-1:0]            s1_column_reg;
    logic [NCH-1:0][PIX_W-1:0]   s1_first_reg;
    logic [NCH-1:0][PIX_W-1:0]   s1_second_reg;
    logic [WIDTH_W-1:0]          s1_w_reg;
    logic [START_W-1:0]          s1_k_reg;
    logic                        s2_valid_reg;
    slfb_div_t                   s2_reg;
    slfb_div_t                   s2_next;

    logic                        in_range;
    logic                        pass;
    logic                        take1;
    logic                        take2;
    logic [WIDTH_W-1:0]          w_minus_k;

    always_comb
    begin
        in_range = (in_data.column >= start_col) &&
                   ({1'b0, in_data.column} < end_col);
        pass     = (in_data.second == '0);
        take2    = !s2_valid_reg || dn_take;
        take1    = !s1_valid_reg || take2;
        in_take  = take1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            // drop requests outside the overlap
            if (take1)
                s1_valid_reg <= in_valid && in_range;
            if (take2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            s1_column_reg <= in_data.column;
            s1_first_reg  <= in_data.first;
            s1_second_reg <= in_data.second;
            s1_w_reg      <= end_col - {1'b0, start_col};
            // k of zero turns the blend into a pass of the first pixel
            s1_k_reg      <= pass ? '0 : (in_data.column - start_col);
        end
    end

    always_comb
    begin
        w_minus_k      = s1_w_reg - {1'b0, s1_k_reg};
        s2_next        = '0;
        s2_next.valid  = s1_valid_reg;
        s2_next.column = s1_column_reg;
        s2_next.w      = s1_w_reg;
        for (int c = 0; c < NCH; c++)
        begin
            s2_next.rem[c] = SUM_W'(s1_first_reg[c]) * SUM_W'(w_minus_k) +
                             SUM_W'(s1_second_reg[c]) * SUM_W'(s1_k_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take2)
            s2_reg <= s2_next;
    end

    always_comb
    begin
        dn       = s2_reg;
        dn.valid = s2_valid_reg;
    end

endmodule

/* hw/rtl/slfb_cell.sv */
module slfb_cell #(
    parameter int unsigned BIT = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  slfb_pkg::slfb_div_t     up,
    output logic                    up_take,
    input  logic                    dn_take,
    output slfb_pkg::slfb_div_t     dn
);
    import slfb_pkg::*;

    logic                 valid_reg;
    slfb_div_t            data_reg;
    slfb_div_t            data_next;
    logic [SUM_W-1:0]     divisor;

    assign up_take = !valid_reg || dn_take;

    // one restoring step: settle quotient bit BIT
    always_comb
    begin
        divisor   = SUM_W'(up.w) << BIT;
        data_next = up;
        for (int c = 0; c < NCH; c++)
        begin
            if (up.rem[c] >= divisor)
            begin
                data_next.rem[c]      = up.rem[c] - divisor;
                data_next.quo[c][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_take)
            valid_reg <= up.valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_take)
            data_reg <= data_next;
    end

    always_comb
    begin
        dn       = data_reg;
        dn.valid = valid_reg;
    end

endmodule

/* hw/rtl/seam_linear_feather_blend_unit.sv */
// Seam feather blend: one pixel pair in, at most one blended pixel out.
// pair  : request carrying a column and one 3x8-bit pixel from each image.
// blend : request carrying the column and the blended 3x8-bit pixel.
// wr_en/wr_index/wr_data : register writes (0 start_column, 1 image_width),
//   taken at any edge with wr_en high; other indexes are ignored.
// A pair whose column lies outside [start_column, min(image_width,
// MAX_WIDTH)) is accepted and gives no result.
// After its pair is accepted, a result passes two front stages, eight
// divider cells and one output register before it leaves on blend.
// Throughput: one pair per clock while blend does not stall. The quotient
// is produced by a chain of eight cells, one quotient bit per cell, each
// passing its partial remainder to the next cell whenever the pipe moves.
// When blend stalls, full stages hold; empty stages still advance, so the
// pipe fills up and pair.ready drops only when no stage is free.
// Reset (rst_n low, asynchronous) empties the pipe and sets start_column to
// 0 and image_width to 4096.
module seam_linear_feather_blend_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    slfb_in_if.sink                            pair,
    slfb_out_if.source                         blend,
    input  logic                               wr_en,
    input  logic [slfb_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [slfb_pkg::CFG_DATA_W-1:0]    wr_data
);
    import slfb_pkg::*;

    logic [START_W-1:0]   start_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic [WIDTH_W-1:0]   end_col;

    slfb_pair_t           pair_data;
    slfb_div_t            chain [PIX_W+1];
    logic                 take  [PIX_W+1];
    logic                 front_take;

    logic                 out_valid_reg;
    slfb_div_t            out_reg;
    logic                 take_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_RESET;
            width_reg <= WIDTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_START_COLUMN: start_reg <= wr_data[START_W-1:0];
                REG_IMAGE_WIDTH:  width_reg <= wr_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign end_col = (width_reg > END_CAP) ? END_CAP : width_reg;

    always_comb
    begin
        pair_data.column    = pair.column;
        pair_data.first[0]  = pair.first_c0;
        pair_data.first[1]  = pair.first_c1;
        pair_data.first[2]  = pair.first_c2;
        pair_data.second[0] = pair.second_c0;
        pair_data.second[1] = pair.second_c1;
        pair_data.second[2] = pair.second_c2;
    end

    slfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start_col (start_reg),
        .end_col   (end_col),
        .in_valid  (pair.valid),
        .in_data   (pair_data),
        .in_take   (front_take),
        .dn_take   (take[0]),
        .dn        (chain[0])
    );

    assign pair.ready = front_take;

    for (genvar i = 0; i < PIX_W; i++)
    begin : g_cell
        slfb_cell #(
            .BIT (PIX_W - 1 - i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .up      (chain[i]),
            .up_take (take[i]),
            .dn_take (take[i+1]),
            .dn      (chain[i+1])
        );
    end

    assign take_out     = !out_valid_reg || blend.ready;
    assign take[PIX_W]  = take_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take_out)
            out_valid_reg <= chain[PIX_W].valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
            out_reg <= chain[PIX_W];
    end

    assign blend.valid      = out_valid_reg;
    assign blend.out_column = out_reg.column;
    assign blend.out_c0     = out_reg.quo[0];
    assign blend.out_c1     = out_reg.quo[1];
    assign blend.out_c2     = out_reg.quo[2];

endmodule

/* hw/rtl/slfb_checker.sv */
module slfb_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pair_ready,
    input  logic                               blend_valid,
    input  logic                               blend_ready,
    input  logic [slfb_pkg::COL_W-1:0]         blend_column,
    input  logic [slfb_pkg::PIX_W-1:0]         blend_c0,
    input  logic [slfb_pkg::PIX_W-1:0]         blend_c1,
    input  logic [slfb_pkg::PIX_W-1:0]         blend_c2,
    input  logic                               wr_en,
    input  logic [slfb_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [slfb_pkg::CFG_DATA_W-1:0]    wr_data
);
    import slfb_pkg::*;

    logic [START_W-1:0]   start_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic [WIDTH_W-1:0]   end_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_RESET;
            width_reg <= WIDTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_START_COLUMN: start_reg <= wr_data[START_W-1:0];
                REG_IMAGE_WIDTH:  width_reg <= wr_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign end_col = (width_reg > END_CAP) ? END_CAP : width_reg;

    // an empty output register means every stage can advance
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !blend_valid |-> pair_ready)
        else $error("pair not ready while output is empty");

    a_column_low: assert property (@(posedge clk) disable iff (!rst_n)
        blend_valid |-> (blend_column >= start_reg))
        else $error("result column before the overlap");

    a_column_high: assert property (@(posedge clk) disable iff (!rst_n)
        blend_valid |-> ({1'b0, blend_column} < end_col))
        else $error("result column past the overlap");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        blend_valid && !blend_ready |=> blend_valid && $stable(blend_column) &&
            $stable(blend_c0) && $stable(blend_c1) && $stable(blend_c2))
        else $error("stalled result changed");

endmodule

bind seam_linear_feather_blend_unit slfb_checker u_slfb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pair_ready   (pair.ready),
    .blend_valid  (blend.valid),
    .blend_ready  (blend.ready),
    .blend_column (blend.out_column),
    .blend_c0     (blend.out_c0),
    .blend_c1     (blend.out_c1),
    .blend_c2     (blend.out_c2),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
);
